@@ design/lcsm_pkg.sv @@
`default_nettype none

package lcsm_pkg;

    // charge phases
    typedef enum logic [1:0] {
        PH_CC     = 2'd0,
        PH_TOPOFF = 2'd1,
        PH_FULL   = 2'd2,
        PH_ERROR  = 2'd3
    } t_phase;

    // request kinds; the last code leaves the state as it is, but still loads the selected CV and returns a result
    typedef enum logic [1:0] {
        ACT_POLL    = 2'd0,
        ACT_ENABLE  = 2'd1,
        ACT_DISABLE = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 23;

    localparam logic [CFG_INDEX_W-1:0] REG_TOPOFF_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RECHARGE_MARGIN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_CURRENT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NOMINAL_CV       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TOPOFF_LIMIT     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_RULES       = 3'd5;

    localparam logic [22:0] RST_TOPOFF_THRESHOLD = 23'd4200000;
    localparam logic [19:0] RST_RECHARGE_MARGIN  = 20'd150000;
    localparam logic [22:0] RST_FULL_CURRENT     = 23'd150000;
    localparam logic [22:0] RST_NOMINAL_CV       = 23'd4350000;
    localparam logic [15:0] RST_TOPOFF_LIMIT     = 16'd10800;

    // temperature zones outside the normal band
    localparam logic [2:0] ZONE_COLD = 3'd0;
    localparam logic [2:0] ZONE_HOT  = 3'd5;

    // milli to micro scaling
    localparam int UNIT_SCALE = 1000;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [22:0] topoff_threshold_uv;
        logic [19:0] recharge_margin_uv;
        logic [22:0] full_current_ua;
        logic [22:0] nominal_cv_uv;
        logic [15:0] topoff_limit_seconds;
        logic        temp_rules_enable;
    } t_cfg;

    // classified request as it travels through the queue
    typedef struct packed {
        t_action     action;
        logic [31:0] now_seconds;
        logic        vbat_above_topoff;
        logic        ibat_above_full;
        logic        vbat_below_recharge;
        logic        zone_extreme;
        logic [22:0] cv_uv;
    } t_item;

    typedef struct packed {
        logic                   full;
        logic                   empty;
        logic [QUEUE_CNT_W-1:0] count;
    } t_q_stat;

endpackage

`default_nettype wire

@@ design/linear_charge_state_machine_core.sv @@
`default_nettype none

// Constant current / top-off / full / error charge sequencer. Each request is a
// poll tick, an enable or a disable, and returns exactly one result that shows
// the phase, charger enable, selected CV, poll speed and phase times after that
// request. Throughput is one request per clock while the result is not held by
// a stall; a request is written into the queue, and the state update then
// takes it from there and loads the result register. The front scales voltage
// and current to micro units and does the threshold compares; a two-entry
// queue decouples it from the back, whose state update (32-bit subtracts of
// the charge and top-off start times from the request time, and compares) sets the
// rate. Configuration registers reset to 4200000 uV top-off threshold,
// 150000 uV recharge margin, 150000 uA full current, 4350000 uV nominal CV,
// 10800 s top-off limit and temperature rules off; write them only while no
// request is in flight, since the front compares against them on entry.

module linear_charge_state_machine_core import lcsm_pkg::*; #(
    parameter int unsigned FULL_POLL_COUNT = 6
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // request channel
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_action,
    input  logic [31:0]            i_now_seconds,
    input  logic [12:0]            i_vbat_mv,
    input  logic signed [13:0]     i_ibat_ma,
    input  logic [2:0]             i_temp_zone,
    input  logic [22:0]            i_zone_cv_uv,
    // result channel
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_charge_phase,
    output logic                   o_charger_on,
    output logic [22:0]            o_selected_cv_uv,
    output logic                   o_slow_poll,
    output logic [31:0]            o_cc_seconds,
    output logic [31:0]            o_topoff_seconds,
    output logic [31:0]            o_total_seconds
);

    t_cfg    r_cfg;
    t_item   w_front_item;
    t_item   w_back_item;
    t_q_stat w_q_stat;
    logic    w_push;
    logic    w_pop;

    // configuration registers; writes to unlisted indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.topoff_threshold_uv  <= RST_TOPOFF_THRESHOLD;
            r_cfg.recharge_margin_uv   <= RST_RECHARGE_MARGIN;
            r_cfg.full_current_ua      <= RST_FULL_CURRENT;
            r_cfg.nominal_cv_uv        <= RST_NOMINAL_CV;
            r_cfg.topoff_limit_seconds <= RST_TOPOFF_LIMIT;
            r_cfg.temp_rules_enable    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TOPOFF_THRESHOLD: begin
                    r_cfg.topoff_threshold_uv <= i_cfg_data[22:0];
                end
                REG_RECHARGE_MARGIN: begin
                    r_cfg.recharge_margin_uv <= i_cfg_data[19:0];
                end
                REG_FULL_CURRENT: begin
                    r_cfg.full_current_ua <= i_cfg_data[22:0];
                end
                REG_NOMINAL_CV: begin
                    r_cfg.nominal_cv_uv <= i_cfg_data[22:0];
                end
                REG_TOPOFF_LIMIT: begin
                    r_cfg.topoff_limit_seconds <= i_cfg_data[15:0];
                end
                REG_TEMP_RULES: begin
                    r_cfg.temp_rules_enable <= i_cfg_data[0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // front: scale and classify each request against the thresholds
    lcsm_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_q_stat      (w_q_stat),
        .i_cfg         (r_cfg),
        .i_action      (i_action),
        .i_now_seconds (i_now_seconds),
        .i_vbat_mv     (i_vbat_mv),
        .i_ibat_ma     (i_ibat_ma),
        .i_temp_zone   (i_temp_zone),
        .i_zone_cv_uv  (i_zone_cv_uv),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    // short queue so the front keeps taking requests while a result is stalled
    lcsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_back_item),
        .o_stat  (w_q_stat)
    );

    // back: phase machine, timers and the result register
    lcsm_back #(
        .FULL_POLL_COUNT (FULL_POLL_COUNT)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (w_back_item),
        .i_q_stat         (w_q_stat),
        .i_cfg            (r_cfg),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_charge_phase   (o_charge_phase),
        .o_charger_on     (o_charger_on),
        .o_selected_cv_uv (o_selected_cv_uv),
        .o_slow_poll      (o_slow_poll),
        .o_cc_seconds     (o_cc_seconds),
        .o_topoff_seconds (o_topoff_seconds),
        .o_total_seconds  (o_total_seconds)
    );

    // full and error phases always leave the charger output off
    a_off_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_charge_phase == PH_FULL || o_charge_phase == PH_ERROR))
        |-> !o_charger_on)
        else $error("charger on in full or error phase");

    // queue occupancy never exceeds its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    // the back only takes a request from a non-empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_q_stat.count != '0) && (!o_valid || i_ready))
        else $error("pop from empty queue or into a held result");

    // reset leaves no result pending and an empty queue
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && w_q_stat.empty)
        else $error("result or queue not cleared by reset");

endmodule

`default_nettype wire

@@ design/lcsm_front.sv @@
`default_nettype none

module lcsm_front import lcsm_pkg::*; (
    input  logic               i_valid,
    output logic               o_ready,
    input  t_q_stat            i_q_stat,
    input  t_cfg               i_cfg,
    input  logic [1:0]         i_action,
    input  logic [31:0]        i_now_seconds,
    input  logic [12:0]        i_vbat_mv,
    input  logic signed [13:0] i_ibat_ma,
    input  logic [2:0]         i_temp_zone,
    input  logic [22:0]        i_zone_cv_uv,
    output logic               o_push,
    output t_item              o_item
);

    localparam logic signed [24:0] IBAT_SCALE = 25'(UNIT_SCALE);

    logic [22:0]        w_vbat_uv;
    logic signed [24:0] w_ibat_ua;
    logic signed [24:0] w_full_ua;
    logic [22:0]        w_cv_uv;
    logic [22:0]        w_margin_uv;
    logic [22:0]        w_recharge_uv;

    // vbat tops out at 8191000 uV, which still fits 23 bits
    assign w_vbat_uv = 23'(i_vbat_mv) * 23'(UNIT_SCALE);
    assign w_ibat_ua = 25'(i_ibat_ma) * IBAT_SCALE;
    assign w_full_ua = $signed({2'b00, i_cfg.full_current_ua});

    assign w_cv_uv = (i_cfg.temp_rules_enable && (i_zone_cv_uv != '0))
                   ? i_zone_cv_uv : i_cfg.nominal_cv_uv;

    // recharge threshold saturates at zero
    assign w_margin_uv   = 23'(i_cfg.recharge_margin_uv);
    assign w_recharge_uv = (w_cv_uv > w_margin_uv) ? (w_cv_uv - w_margin_uv) : '0;

    assign o_ready = !i_q_stat.full;
    assign o_push  = i_valid && !i_q_stat.full;

    always_comb begin
        o_item.action              = t_action'(i_action);
        o_item.now_seconds         = i_now_seconds;
        o_item.vbat_above_topoff   = w_vbat_uv > i_cfg.topoff_threshold_uv;
        o_item.ibat_above_full     = w_ibat_ua > w_full_ua;
        o_item.vbat_below_recharge = w_vbat_uv < w_recharge_uv;
        o_item.zone_extreme        = i_temp_zone inside {ZONE_COLD, ZONE_HOT};
        o_item.cv_uv               = w_cv_uv;
    end

endmodule

`default_nettype wire

@@ design/lcsm_queue.sv @@
`default_nettype none

module lcsm_queue import lcsm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output t_item   o_item,
    output t_q_stat o_stat
);

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_CNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

endmodule

`default_nettype wire

@@ design/lcsm_back.sv @@
`default_nettype none

module lcsm_back import lcsm_pkg::*; #(
    parameter int unsigned FULL_POLL_COUNT = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  t_q_stat     i_q_stat,
    input  t_cfg        i_cfg,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_charge_phase,
    output logic        o_charger_on,
    output logic [22:0] o_selected_cv_uv,
    output logic        o_slow_poll,
    output logic [31:0] o_cc_seconds,
    output logic [31:0] o_topoff_seconds,
    output logic [31:0] o_total_seconds
);

    // state registers double as the result register
    t_phase      r_phase,        n_phase;
    logic [31:0] r_charge_start, n_charge_start;
    logic [31:0] r_topoff_start, n_topoff_start;
    logic [2:0]  r_low_count,    n_low_count;
    logic        r_recovered,    n_recovered;
    logic        r_out_en,       n_out_en;
    logic        r_slow,         n_slow;
    logic [31:0] r_cc_time,      n_cc_time;
    logic [31:0] r_topoff_time,  n_topoff_time;
    logic [31:0] r_total_time,   n_total_time;
    logic [22:0] r_cv;
    logic        r_out_valid;

    logic [31:0] w_cc_elapsed;
    logic [31:0] w_topoff_elapsed;
    logic        w_limit_hit;
    logic [2:0]  w_count_inc;
    logic [2:0]  w_topoff_count;
    logic        w_topoff_done;

    assign o_pop = !i_q_stat.empty && (!r_out_valid || i_ready);

    assign w_cc_elapsed     = i_item.now_seconds - r_charge_start;
    assign w_topoff_elapsed = i_item.now_seconds - r_topoff_start;
    assign w_limit_hit      = w_topoff_elapsed >= 32'(i_cfg.topoff_limit_seconds);
    assign w_count_inc      = r_low_count + 3'd1;

    // low-current run in top-off; skipped when the time limit already ends it
    always_comb begin
        w_topoff_count = r_low_count;
        w_topoff_done  = 1'b0;
        if (w_limit_hit) begin
            w_topoff_done = 1'b1;
        end else if (i_item.ibat_above_full) begin
            w_topoff_count = '0;
        end else if (w_count_inc >= 3'(FULL_POLL_COUNT)) begin
            w_topoff_count = '0;
            w_topoff_done  = 1'b1;
        end else begin
            w_topoff_count = w_count_inc;
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (i_item.action)
            ACT_ENABLE: begin
                n_phase = PH_CC;
            end
            ACT_DISABLE: begin
                n_phase = PH_ERROR;
            end
            ACT_POLL: begin
                case (r_phase)
                    PH_CC: begin
                        if (i_item.vbat_above_topoff) begin
                            n_phase = PH_TOPOFF;
                        end
                    end
                    PH_TOPOFF: begin
                        if (w_topoff_done) begin
                            n_phase = PH_FULL;
                        end
                    end
                    PH_FULL: begin
                        if (i_item.vbat_below_recharge) begin
                            n_phase = PH_CC;
                        end
                    end
                    PH_ERROR: begin
                        if (i_cfg.temp_rules_enable && !i_item.zone_extreme && !r_recovered) begin
                            n_phase = PH_CC;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // datapath registers that follow the phase
    always_comb begin
        n_charge_start = r_charge_start;
        n_topoff_start = r_topoff_start;
        n_low_count    = r_low_count;
        n_recovered    = r_recovered;
        n_out_en       = r_out_en;
        n_slow         = r_slow;
        n_cc_time      = r_cc_time;
        n_topoff_time  = r_topoff_time;
        n_total_time   = r_total_time;
        case (i_item.action)
            ACT_ENABLE: begin
                n_charge_start = i_item.now_seconds;
            end
            ACT_DISABLE: begin
                n_out_en = 1'b0;
            end
            ACT_POLL: begin
                case (r_phase)
                    PH_CC: begin
                        n_cc_time     = w_cc_elapsed;
                        n_topoff_time = '0;
                        n_total_time  = w_cc_elapsed;
                        n_out_en      = 1'b1;
                        if (i_item.vbat_above_topoff) begin
                            n_topoff_start = i_item.now_seconds;
                        end
                    end
                    PH_TOPOFF: begin
                        n_cc_time     = '0;
                        n_topoff_time = w_topoff_elapsed;
                        n_total_time  = w_cc_elapsed;
                        n_low_count   = w_topoff_count;
                        n_out_en      = !w_topoff_done;
                    end
                    PH_FULL: begin
                        n_cc_time     = '0;
                        n_topoff_time = '0;
                        n_total_time  = '0;
                        n_slow        = !i_item.vbat_below_recharge;
                        if (i_item.vbat_below_recharge) begin
                            n_charge_start = i_item.now_seconds;
                        end
                    end
                    PH_ERROR: begin
                        n_cc_time     = '0;
                        n_topoff_time = '0;
                        n_total_time  = '0;
                        n_out_en      = 1'b0;
                        if (i_cfg.temp_rules_enable) begin
                            if (i_item.zone_extreme) begin
                                n_recovered = 1'b0;
                            end else if (!r_recovered) begin
                                n_recovered    = 1'b1;
                                n_charge_start = i_item.now_seconds;
                            end
                        end
                    end
                    default: begin
                        n_out_en = r_out_en;
                    end
                endcase
            end
            default: begin
                n_out_en = r_out_en;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_CC;
            r_charge_start <= '0;
            r_topoff_start <= '0;
            r_low_count    <= '0;
            r_recovered    <= 1'b0;
            r_out_en       <= 1'b0;
            r_slow         <= 1'b0;
            r_cc_time      <= '0;
            r_topoff_time  <= '0;
            r_total_time   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase        <= n_phase;
                r_charge_start <= n_charge_start;
                r_topoff_start <= n_topoff_start;
                r_low_count    <= n_low_count;
                r_recovered    <= n_recovered;
                r_out_en       <= n_out_en;
                r_slow         <= n_slow;
                r_cc_time      <= n_cc_time;
                r_topoff_time  <= n_topoff_time;
                r_total_time   <= n_total_time;
                r_out_valid    <= 1'b1;
            end else if (i_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cv <= i_item.cv_uv;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_charge_phase   = r_phase;
    assign o_charger_on     = r_out_en;
    assign o_selected_cv_uv = r_cv;
    assign o_slow_poll      = r_slow;
    assign o_cc_seconds     = r_cc_time;
    assign o_topoff_seconds = r_topoff_time;
    assign o_total_seconds  = r_total_time;

endmodule

`default_nettype wire
